[src/pcsa_pkg.sv]
// pcsa_pkg: types, constants and helper functions shared by the chi-square accumulator.
// Depends on nothing; the design modules refer to it by scoped names.
package pcsa_pkg;

	// Bin queue between front and back
	localparam int QDepth = 2;
	localparam int QPtrW  = $clog2(QDepth);
	localparam int QCntW  = $clog2(QDepth + 1);

	// Shared restoring divider
	localparam int DivW    = 62;
	localparam int DivSorW = 24;
	localparam int DivCntW = $clog2(DivW);

	localparam logic [47:0] SumMax = '1;

	// CORDIC and square-root sequencing
	localparam int CordicSteps = 15;
	localparam int SqrtSteps   = 31;
	localparam int IterCntW    = $clog2(SqrtSteps);

	localparam logic signed [33:0] CordicGain = 34'sd652032874;
	localparam logic signed [33:0] OneQ30     = 34'sd1073741824;

	typedef enum logic [1:0] {
		KIND_SKIP,
		KIND_BAD,
		KIND_CALC
	} kind_t;

	typedef enum logic [1:0] {
		REG_LAMBDA_THETA,
		REG_LAMBDA_PHI,
		REG_LAMBDA_THETA_PHI,
		REG_NORMALISATION
	} reg_idx_t;

	typedef enum logic [3:0] {
		BK_IDLE,
		BK_PREP,
		BK_PROD,
		BK_ITER,
		BK_TERM1,
		BK_TERM2,
		BK_SUMB,
		BK_MULN,
		BK_DIV1S,
		BK_DIV1,
		BK_RES,
		BK_DIV2S,
		BK_DIV2,
		BK_SQ1,
		BK_SQ2,
		BK_DONE
	} bk_state_t;

	typedef struct packed {
		logic signed [15:0] cos_theta;
		logic signed [15:0] phi_angle;
		logic [23:0]        measured;
		logic [23:0]        uncertainty;
		logic               last_bin;
		kind_t              kind;
	} item_t;

	typedef struct packed {
		logic signed [15:0] lambda_theta;
		logic signed [15:0] lambda_phi;
		logic signed [15:0] lambda_theta_phi;
		logic [24:0]        normalisation;
	} cfg_t;

	typedef struct packed {
		logic signed [33:0] x;
		logic signed [33:0] y;
		logic signed [17:0] z;
		logic               neg;
	} cordic_t;

	// Arctangent of 2^-i in binary-angle units
	function automatic logic [13:0] atan_lut(input logic [3:0] i);
		logic [13:0] v;
		unique case (i)
			4'd0:    v = 14'd8192;
			4'd1:    v = 14'd4836;
			4'd2:    v = 14'd2555;
			4'd3:    v = 14'd1297;
			4'd4:    v = 14'd651;
			4'd5:    v = 14'd326;
			4'd6:    v = 14'd163;
			4'd7:    v = 14'd81;
			4'd8:    v = 14'd41;
			4'd9:    v = 14'd20;
			4'd10:   v = 14'd10;
			4'd11:   v = 14'd5;
			4'd12:   v = 14'd3;
			4'd13:   v = 14'd1;
			4'd14:   v = 14'd1;
			default: v = 14'd0;
		endcase
		return v;
	endfunction

	// Fold quadrants 2 and 3 onto 1 and 4, remember to negate
	function automatic cordic_t cordic_init(input logic signed [15:0] a);
		cordic_t            c;
		logic signed [17:0] ae;
		ae    = $signed({{2{a[15]}}, a});
		c.x   = CordicGain;
		c.y   = '0;
		c.neg = 1'b0;
		if (ae > 18'sd16384) begin
			ae    = ae - 18'sd32768;
			c.neg = 1'b1;
		end else if (ae < -18'sd16384) begin
			ae    = ae + 18'sd32768;
			c.neg = 1'b1;
		end
		c.z = ae;
		return c;
	endfunction

	function automatic cordic_t cordic_step(input cordic_t c, input logic [3:0] i);
		cordic_t            n;
		logic signed [33:0] xs;
		logic signed [33:0] ys;
		logic signed [17:0] zs;
		logic signed [17:0] at;
		xs    = c.x;
		ys    = c.y;
		zs    = c.z;
		at    = $signed({4'b0000, atan_lut(i)});
		n.neg = c.neg;
		if (zs >= 18'sd0) begin
			n.x = xs - (ys >>> i);
			n.y = ys + (xs >>> i);
			n.z = zs - at;
		end else begin
			n.x = xs + (ys >>> i);
			n.y = ys - (xs >>> i);
			n.z = zs + at;
		end
		return n;
	endfunction

	// Clamp to unit range, undo the fold, floor to Q.15
	function automatic logic signed [16:0] cordic_cos(input cordic_t c);
		logic signed [33:0] xs;
		logic signed [33:0] sh;
		xs = c.x;
		if (xs > OneQ30) begin
			xs = OneQ30;
		end else if (xs < -OneQ30) begin
			xs = -OneQ30;
		end
		if (c.neg) begin
			xs = -xs;
		end
		sh = xs >>> 15;
		return sh[16:0];
	endfunction

endpackage

[src/pcsa_in_if.sv]
// pcsa_in_if: valid/ready channel that carries one histogram bin.
// Depends on nothing.
interface pcsa_in_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] cos_theta;
	logic signed [15:0] phi_angle;
	logic [23:0]        measured;
	logic [23:0]        uncertainty;
	logic               last_bin;

	modport source (output valid, cos_theta, phi_angle, measured, uncertainty, last_bin,
		input ready);
	modport sink (input valid, cos_theta, phi_angle, measured, uncertainty, last_bin,
		output ready);
endinterface

[src/pcsa_out_if.sv]
// pcsa_out_if: valid/ready channel that carries one chi-square result.
// Depends on nothing.
interface pcsa_out_if;
	logic        valid;
	logic        ready;
	logic [47:0] chi_square;
	logic        saturated;
	logic        zero_error_seen;

	modport source (output valid, chi_square, saturated, zero_error_seen, input ready);
	modport sink (input valid, chi_square, saturated, zero_error_seen, output ready);
endinterface

[src/polarisation_chi_square_accum.sv]
// polarisation_chi_square_accum: top level; configuration registers, front queue, back engine.
// Depends on pcsa_pkg, pcsa_in_if, pcsa_out_if, pcsa_front, pcsa_back.
//
//  channel   dir  handshake     payload
//  in_ch     in   valid/ready   cos_theta, phi_angle, measured, uncertainty, last_bin
//  out_ch    out  valid/ready   chi_square, saturated, zero_error_seen
//  cfg       in   cfg_we        cfg_index, cfg_wdata
//
// A bin with nonzero content and error passes in the back engine through the shared
// square-root/CORDIC loop, two passes of the bit-serial divider, and the multiply and
// add steps around them. Empty or zero-error bins go straight from idle to done.
// The front queue holds two bins; the result sits in an output register, so the back
// engine stalls only on a new last bin while an earlier result waits for transfer.
// Reset (arst_n low) clears the sum, flags, queue and output; registers return to defaults.
module polarisation_chi_square_accum (
	input  logic        clk,
	input  logic        arst_n,
	pcsa_in_if.sink     in_ch,
	pcsa_out_if.source  out_ch,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [24:0] cfg_wdata
);

	pcsa_pkg::cfg_t  cfg_q;
	logic            q_valid;
	pcsa_pkg::item_t q_item;
	logic            q_pop;

	// Configuration register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.lambda_theta     <= 16'sd8192;
			cfg_q.lambda_phi       <= '0;
			cfg_q.lambda_theta_phi <= '0;
			cfg_q.normalisation    <= 25'd12339200;
		end else if (cfg_we) begin
			unique case (pcsa_pkg::reg_idx_t'(cfg_index))
				pcsa_pkg::REG_LAMBDA_THETA:     cfg_q.lambda_theta     <= cfg_wdata[15:0];
				pcsa_pkg::REG_LAMBDA_PHI:       cfg_q.lambda_phi       <= cfg_wdata[15:0];
				pcsa_pkg::REG_LAMBDA_THETA_PHI: cfg_q.lambda_theta_phi <= cfg_wdata[15:0];
				pcsa_pkg::REG_NORMALISATION:    cfg_q.normalisation    <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	pcsa_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ch   (in_ch),
		.q_valid (q_valid),
		.q_item  (q_item),
		.q_pop   (q_pop)
	);

	pcsa_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.q_valid (q_valid),
		.q_item  (q_item),
		.q_pop   (q_pop),
		.out_ch  (out_ch)
	);

endmodule

[src/pcsa_front.sv]
// pcsa_front: accepts bins, classifies them and holds them in a short queue.
// Depends on pcsa_pkg and pcsa_in_if.
module pcsa_front (
	input  logic            clk,
	input  logic            arst_n,
	pcsa_in_if.sink         in_ch,
	output logic            q_valid,
	output pcsa_pkg::item_t q_item,
	input  logic            q_pop
);

	pcsa_pkg::item_t                  mem_q [pcsa_pkg::QDepth];
	logic [pcsa_pkg::QPtrW-1:0]       wptr_q;
	logic [pcsa_pkg::QPtrW-1:0]       rptr_q;
	logic [pcsa_pkg::QCntW-1:0]       count_q;
	logic                             push;
	logic                             pop;
	pcsa_pkg::item_t                  item_in;

	assign in_ch.ready = (count_q != pcsa_pkg::QCntW'(pcsa_pkg::QDepth));
	assign push        = in_ch.valid && in_ch.ready;
	assign q_valid     = (count_q != '0);
	assign pop         = q_pop && q_valid;
	assign q_item      = mem_q[rptr_q];

	// Classify: empty bin, zero error, or full computation
	always_comb begin
		item_in.cos_theta   = in_ch.cos_theta;
		item_in.phi_angle   = in_ch.phi_angle;
		item_in.measured    = in_ch.measured;
		item_in.uncertainty = in_ch.uncertainty;
		item_in.last_bin    = in_ch.last_bin;
		priority if (in_ch.measured == '0) begin
			item_in.kind = pcsa_pkg::KIND_SKIP;
		end else if (in_ch.uncertainty == '0) begin
			item_in.kind = pcsa_pkg::KIND_BAD;
		end else begin
			item_in.kind = pcsa_pkg::KIND_CALC;
		end
	end

	// Store transfers
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= item_in;
		end
	end

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= rptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= pcsa_pkg::QCntW'(pcsa_pkg::QDepth))
		else $error("queue count beyond depth");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid)
		else $error("pop from empty queue");

	a_push_count: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> count_q == $past(count_q) + 1'b1)
		else $error("push lost");

endmodule

[src/pcsa_div.sv]
// pcsa_div: restoring divider, one quotient bit per cycle, shared by both divisions.
// Depends on pcsa_pkg.
module pcsa_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [pcsa_pkg::DivW-1:0]    dividend,
	input  logic [pcsa_pkg::DivSorW-1:0] divisor,
	output logic                         done,
	output logic [pcsa_pkg::DivW-1:0]    quotient
);

	logic                          busy_q;
	logic                          done_q;
	logic [pcsa_pkg::DivCntW-1:0]  cnt_q;
	logic [pcsa_pkg::DivW-1:0]     quo_q;
	logic [pcsa_pkg::DivSorW-1:0]  rem_q;
	logic [pcsa_pkg::DivSorW-1:0]  sor_q;
	logic [pcsa_pkg::DivSorW:0]    trial;
	logic [pcsa_pkg::DivSorW:0]    diff;

	assign trial    = {rem_q, quo_q[pcsa_pkg::DivW-1]};
	assign diff     = trial - {1'b0, sor_q};
	assign done     = done_q;
	assign quotient = quo_q;

	// Shift in one dividend bit, subtract when it fits
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			sor_q <= divisor;
		end else if (busy_q) begin
			if (!diff[pcsa_pkg::DivSorW]) begin
				rem_q <= diff[pcsa_pkg::DivSorW-1:0];
				quo_q <= {quo_q[pcsa_pkg::DivW-2:0], 1'b1};
			end else begin
				rem_q <= trial[pcsa_pkg::DivSorW-1:0];
				quo_q <= {quo_q[pcsa_pkg::DivW-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == pcsa_pkg::DivCntW'(pcsa_pkg::DivW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy_q))
		else $error("done without a running division");

	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> !start)
		else $error("divider restarted while busy");

	a_rem_below: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && !$rose(busy_q)) |-> rem_q < sor_q)
		else $error("partial remainder not below divisor");

endmodule

[src/pcsa_back.sv]
// pcsa_back: per-bin model evaluation, residual, chi-square term and saturating sum.
// Depends on pcsa_pkg, pcsa_div and pcsa_out_if.
module pcsa_back (
	input  logic            clk,
	input  logic            arst_n,
	input  pcsa_pkg::cfg_t  cfg,
	input  logic            q_valid,
	input  pcsa_pkg::item_t q_item,
	output logic            q_pop,
	pcsa_out_if.source      out_ch
);

	pcsa_pkg::bk_state_t state_q;
	pcsa_pkg::bk_state_t state_nx;

	pcsa_pkg::item_t     it_q;
	logic [pcsa_pkg::IterCntW-1:0] cnt_q;

	pcsa_pkg::cordic_t   cp_lane_q;
	pcsa_pkg::cordic_t   c2p_lane_q;
	logic [30:0]         c2_q;
	logic [61:0]         sv_q;
	logic [61:0]         sr_q;
	logic [61:0]         sb_q;
	logic signed [47:0]  ltc_q;
	logic signed [47:0]  lps_q;
	logic signed [47:0]  ltps_q;
	logic signed [16:0]  cp_q;
	logic signed [16:0]  c2p_q;
	logic signed [64:0]  pa_q;
	logic signed [64:0]  pb_q;
	logic signed [49:0]  b_q;
	logic signed [53:0]  nb_q;
	logic                mneg_q;
	logic signed [54:0]  m_q;
	logic [53:0]         a_q;
	logic [pcsa_pkg::DivW-1:0] zq_q;
	logic [23:0]         hh_q;
	logic [35:0]         hl_q;
	logic [47:0]         ll_q;
	logic [47:0]         term_q;
	logic                tovf_q;

	logic [47:0]         sum_q;
	logic                sat_q;
	logic                bad_q;

	logic                out_valid_q;
	logic [47:0]         out_sum_q;
	logic                out_sat_q;
	logic                out_bad_q;

	// Control decoded from state
	logic                div_start;
	logic                done_ok;
	logic                out_free;

	logic                          div_done;
	logic [pcsa_pkg::DivW-1:0]     div_quo;
	logic [pcsa_pkg::DivW-1:0]     div_dividend;
	logic [pcsa_pkg::DivSorW-1:0]  div_divisor;

	logic [30:0]         s2;
	logic [61:0]         sqrt_trial;
	logic signed [16:0]  den;
	logic [15:0]         den_u;
	logic [52:0]         nb_mag;
	logic signed [55:0]  resid;
	logic [48:0]         sum_nx;
	logic                over;

	assign s2         = 31'h4000_0000 - c2_q;
	assign sqrt_trial = sr_q + sb_q;
	assign out_free   = !out_valid_q || out_ch.ready;

	// Denominator 3 + lambda_theta, forced to one LSB when not positive
	always_comb begin
		den = 17'sd24576 + $signed({cfg.lambda_theta[15], cfg.lambda_theta});
		if (den <= 17'sd0) begin
			den_u = 16'd1;
		end else begin
			den_u = den[15:0];
		end
	end

	assign nb_mag = nb_q[53] ? 53'(-nb_q) : nb_q[52:0];
	assign resid  = $signed({24'b0, it_q.measured, 8'b0}) - 56'(m_q);

	always_comb begin
		if (state_q == pcsa_pkg::BK_DIV1S) begin
			div_dividend = pcsa_pkg::DivW'(nb_mag);
			div_divisor  = pcsa_pkg::DivSorW'(den_u);
		end else begin
			div_dividend = pcsa_pkg::DivW'({a_q, 8'b0});
			div_divisor  = it_q.uncertainty;
		end
	end

	pcsa_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quo)
	);

	// Next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			pcsa_pkg::BK_IDLE: begin
				if (q_valid) begin
					state_nx = (q_item.kind == pcsa_pkg::KIND_CALC) ?
						pcsa_pkg::BK_PREP : pcsa_pkg::BK_DONE;
				end
			end
			pcsa_pkg::BK_PREP:  state_nx = pcsa_pkg::BK_PROD;
			pcsa_pkg::BK_PROD:  state_nx = pcsa_pkg::BK_ITER;
			pcsa_pkg::BK_ITER: begin
				if (cnt_q == pcsa_pkg::IterCntW'(pcsa_pkg::SqrtSteps - 1)) begin
					state_nx = pcsa_pkg::BK_TERM1;
				end
			end
			pcsa_pkg::BK_TERM1: state_nx = pcsa_pkg::BK_TERM2;
			pcsa_pkg::BK_TERM2: state_nx = pcsa_pkg::BK_SUMB;
			pcsa_pkg::BK_SUMB:  state_nx = pcsa_pkg::BK_MULN;
			pcsa_pkg::BK_MULN:  state_nx = pcsa_pkg::BK_DIV1S;
			pcsa_pkg::BK_DIV1S: state_nx = pcsa_pkg::BK_DIV1;
			pcsa_pkg::BK_DIV1: begin
				if (div_done) begin
					state_nx = pcsa_pkg::BK_RES;
				end
			end
			pcsa_pkg::BK_RES:   state_nx = pcsa_pkg::BK_DIV2S;
			pcsa_pkg::BK_DIV2S: state_nx = pcsa_pkg::BK_DIV2;
			pcsa_pkg::BK_DIV2: begin
				if (div_done) begin
					state_nx = pcsa_pkg::BK_SQ1;
				end
			end
			pcsa_pkg::BK_SQ1:   state_nx = pcsa_pkg::BK_SQ2;
			pcsa_pkg::BK_SQ2:   state_nx = pcsa_pkg::BK_DONE;
			pcsa_pkg::BK_DONE: begin
				if (done_ok) begin
					state_nx = pcsa_pkg::BK_IDLE;
				end
			end
			default:            state_nx = pcsa_pkg::BK_IDLE;
		endcase
	end

	// State outputs
	always_comb begin
		q_pop     = (state_q == pcsa_pkg::BK_IDLE) && q_valid;
		div_start = (state_q == pcsa_pkg::BK_DIV1S) || (state_q == pcsa_pkg::BK_DIV2S);
		done_ok   = (state_q == pcsa_pkg::BK_DONE) && (!it_q.last_bin || out_free);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pcsa_pkg::BK_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	// Datapath: each state registers its own products
	always_ff @(posedge clk) begin
		unique case (state_q)
			pcsa_pkg::BK_IDLE: begin
				it_q   <= q_item;
				term_q <= '0;
				tovf_q <= 1'b0;
			end
			pcsa_pkg::BK_PREP: begin
				c2_q       <= 31'(it_q.cos_theta * it_q.cos_theta);
				cp_lane_q  <= pcsa_pkg::cordic_init(it_q.phi_angle);
				c2p_lane_q <= pcsa_pkg::cordic_init($signed({it_q.phi_angle[14:0], 1'b0}));
			end
			pcsa_pkg::BK_PROD: begin
				sv_q  <= {60'(c2_q) * 60'(s2), 2'b00};
				sr_q  <= '0;
				sb_q  <= 62'd1 << 60;
				cnt_q <= '0;
			end
			pcsa_pkg::BK_ITER: begin
				cnt_q <= cnt_q + 1'b1;
				if (sv_q >= sqrt_trial) begin
					sv_q <= sv_q - sqrt_trial;
					sr_q <= (sr_q >> 1) + sb_q;
				end else begin
					sr_q <= sr_q >> 1;
				end
				sb_q <= sb_q >> 2;
				if (cnt_q < pcsa_pkg::IterCntW'(pcsa_pkg::CordicSteps)) begin
					cp_lane_q  <= pcsa_pkg::cordic_step(cp_lane_q, cnt_q[3:0]);
					c2p_lane_q <= pcsa_pkg::cordic_step(c2p_lane_q, cnt_q[3:0]);
				end
			end
			pcsa_pkg::BK_TERM1: begin
				ltc_q  <= 48'(cfg.lambda_theta * $signed({1'b0, c2_q}));
				lps_q  <= 48'(cfg.lambda_phi * $signed({1'b0, s2}));
				ltps_q <= 48'(cfg.lambda_theta_phi * $signed({1'b0, sr_q[30:0]}));
				cp_q   <= pcsa_pkg::cordic_cos(cp_lane_q);
				c2p_q  <= pcsa_pkg::cordic_cos(c2p_lane_q);
			end
			pcsa_pkg::BK_TERM2: begin
				pa_q <= 65'(lps_q * c2p_q);
				pb_q <= 65'(ltps_q * cp_q);
			end
			pcsa_pkg::BK_SUMB: begin
				b_q <= (50'sd1 <<< 43) + 50'(ltc_q) + 50'(pa_q >>> 15) + 50'(pb_q >>> 15);
			end
			pcsa_pkg::BK_MULN: begin
				nb_q   <= 54'($signed({1'b0, cfg.normalisation}) * $signed(b_q[49:22]));
				mneg_q <= b_q[49];
			end
			pcsa_pkg::BK_DIV1: begin
				if (div_done) begin
					m_q <= mneg_q ? -$signed({1'b0, div_quo[53:0]}) :
						$signed({1'b0, div_quo[53:0]});
				end
			end
			pcsa_pkg::BK_RES: begin
				a_q <= resid[55] ? 54'(-resid) : resid[53:0];
			end
			pcsa_pkg::BK_DIV2: begin
				if (div_done) begin
					zq_q <= div_quo;
				end
			end
			pcsa_pkg::BK_SQ1: begin
				tovf_q <= (zq_q[pcsa_pkg::DivW-1:36] != '0);
				hh_q   <= zq_q[35:24] * zq_q[35:24];
				hl_q   <= zq_q[35:24] * zq_q[23:0];
				ll_q   <= zq_q[23:0] * zq_q[23:0];
			end
			pcsa_pkg::BK_SQ2: begin
				term_q <= {hh_q, 24'b0} + {11'b0, hl_q, 1'b0} + {24'b0, ll_q[47:24]};
			end
			default: begin
			end
		endcase
	end

	// Saturating add of the bin term
	assign sum_nx = {1'b0, sum_q} + {1'b0, term_q};
	assign over   = tovf_q || sum_nx[48];

	// Update sum and flags; emit and clear on the last bin
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q       <= '0;
			sat_q       <= 1'b0;
			bad_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (done_ok && it_q.last_bin) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			if (done_ok) begin
				if (it_q.last_bin) begin
					sum_q       <= '0;
					sat_q       <= 1'b0;
					bad_q       <= 1'b0;
				end else begin
					sum_q <= over ? pcsa_pkg::SumMax : sum_nx[47:0];
					sat_q <= sat_q || over;
					bad_q <= bad_q || (it_q.kind == pcsa_pkg::KIND_BAD);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (done_ok && it_q.last_bin) begin
			out_sum_q <= over ? pcsa_pkg::SumMax : sum_nx[47:0];
			out_sat_q <= sat_q || over;
			out_bad_q <= bad_q || (it_q.kind == pcsa_pkg::KIND_BAD);
		end
	end

	assign out_ch.valid           = out_valid_q;
	assign out_ch.chi_square      = out_sum_q;
	assign out_ch.saturated       = out_sat_q;
	assign out_ch.zero_error_seen = out_bad_q;

	a_sat_pins_max: assert property (@(posedge clk) disable iff (!arst_n)
		sat_q |-> sum_q == pcsa_pkg::SumMax)
		else $error("saturation flag set below full scale");

	a_div_done_waited: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == pcsa_pkg::BK_DIV1 || state_q == pcsa_pkg::BK_DIV2))
		else $error("division finished outside a wait state");

	a_iter_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == pcsa_pkg::BK_ITER |->
			cnt_q <= pcsa_pkg::IterCntW'(pcsa_pkg::SqrtSteps - 1))
		else $error("iteration counter overran");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(done_ok && it_q.last_bin) |-> out_free)
		else $error("result overwritten before transfer");

endmodule
